// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the dominated vertex removal modules.
// Depends on nothing; included by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define DVR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Checks that a condition never holds outside reset.
`define DVR_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ----- hdl/dvr_pkg.sv -----
// Package for the dominated vertex removal core: widths, command codes and
// the command and status groups between controller and datapath.
package dvr_pkg;

    localparam int W_BITS        = 64;
    localparam int W_IDX         = 6;
    localparam int NODES_DEFAULT = 64;

    typedef enum logic [1:0] {
        CMD_ROW     = 2'd0,
        CMD_PRESENT = 2'd1,
        CMD_CHECK   = 2'd2,
        CMD_RUN     = 2'd3
    } t_command;

    typedef struct packed {
        logic load_row;
        logic load_present;
        logic load_check;
        logic clr_a;
        logic inc_a;
        logic rd_row_a;
        logic nb_latch;
        logic rd_row_n;
        logic inc_n;
        logic and_row;
        logic find_dom;
        logic out_report;
        logic out_summary;
    } t_dp_cmd;

    typedef struct packed {
        logic check_bit;
        logic a_last;
        logic nb_zero;
        logic nb_bit;
        logic n_last;
        logic cand_zero;
        logic out_free;
    } t_dp_status;

endpackage

// ----- hdl/dvr_ctrl.sv -----
// Controller state machine of the dominated vertex removal core.
// Depends on dvr_pkg and assert_macros.svh; drives the datapath commands.
`include "assert_macros.svh"

module dvr_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [1:0]          i_command,
    input  dvr_pkg::t_dp_status i_status,
    output dvr_pkg::t_dp_cmd    o_cmd,
    output logic                o_stall
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_ROW,
        S_SCAN,
        S_AND,
        S_FIND,
        S_REPORT,
        S_SUMMARY
    } t_state;

    t_state r_state;
    t_state n_state;
    dvr_pkg::t_dp_cmd cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (dvr_pkg::t_command'(i_command))
                        dvr_pkg::CMD_ROW:     cmd.load_row = 1'b1;
                        dvr_pkg::CMD_PRESENT: cmd.load_present = 1'b1;
                        dvr_pkg::CMD_CHECK:   cmd.load_check = 1'b1;
                        dvr_pkg::CMD_RUN: begin
                            cmd.clr_a = 1'b1;
                            n_state   = S_CHECK;
                        end
                        default: ;
                    endcase
                end
            end
            S_CHECK: begin
                if (i_status.check_bit) begin
                    cmd.rd_row_a = 1'b1;
                    n_state      = S_ROW;
                end else if (i_status.a_last) begin
                    n_state = S_SUMMARY;
                end else begin
                    cmd.inc_a = 1'b1;
                end
            end
            S_ROW: begin
                if (!i_status.nb_zero) begin
                    cmd.nb_latch = 1'b1;
                    n_state      = S_SCAN;
                end else if (i_status.a_last) begin
                    n_state = S_SUMMARY;
                end else begin
                    cmd.inc_a = 1'b1;
                    n_state   = S_CHECK;
                end
            end
            S_SCAN: begin
                if (i_status.nb_bit) begin
                    cmd.rd_row_n = 1'b1;
                    n_state      = S_AND;
                end else if (i_status.n_last) begin
                    n_state = S_FIND;
                end else begin
                    cmd.inc_n = 1'b1;
                end
            end
            S_AND: begin
                cmd.and_row = 1'b1;
                if (i_status.n_last) begin
                    n_state = S_FIND;
                end else begin
                    cmd.inc_n = 1'b1;
                    n_state   = S_SCAN;
                end
            end
            S_FIND: begin
                if (!i_status.cand_zero) begin
                    cmd.find_dom = 1'b1;
                    n_state      = S_REPORT;
                end else if (i_status.a_last) begin
                    n_state = S_SUMMARY;
                end else begin
                    cmd.inc_a = 1'b1;
                    n_state   = S_CHECK;
                end
            end
            S_REPORT: begin
                if (i_status.out_free) begin
                    cmd.out_report = 1'b1;
                    if (i_status.a_last) begin
                        n_state = S_SUMMARY;
                    end else begin
                        cmd.inc_a = 1'b1;
                        n_state   = S_CHECK;
                    end
                end
            end
            S_SUMMARY: begin
                if (i_status.out_free) begin
                    cmd.out_summary = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd   = cmd;
    assign o_stall = (r_state != S_IDLE);

    `DVR_ASSERT(a_out_only_when_free, i_clk, i_rst_n,
        (cmd.out_report || cmd.out_summary) |-> i_status.out_free,
        "Result loaded while the output register is occupied.")
    `DVR_ASSERT(a_summary_ends_run, i_clk, i_rst_n,
        cmd.out_summary |=> (r_state == S_IDLE),
        "Run did not end after its summary.")
    `DVR_NEVER(a_one_row_read, i_clk, i_rst_n,
        cmd.rd_row_a && cmd.rd_row_n,
        "Two row reads requested in one cycle.")

endmodule

// ----- hdl/dvr_datapath.sv -----
// Datapath of the dominated vertex removal core: adjacency row memory,
// node masks, node counters and the output register.
// Depends on dvr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dvr_datapath #(
    parameter int NODES = dvr_pkg::NODES_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dvr_pkg::t_dp_cmd                  i_cmd,
    input  logic [dvr_pkg::W_IDX-1:0]         i_row_index,
    input  logic [dvr_pkg::W_BITS-1:0]        i_bits,
    input  logic                              i_stall,
    output dvr_pkg::t_dp_status               o_status,
    output logic                              o_valid,
    output logic                              o_is_summary,
    output logic [dvr_pkg::W_IDX-1:0]         o_pruned_node,
    output logic [dvr_pkg::W_IDX-1:0]         o_dominator_node,
    output logic [dvr_pkg::W_BITS-1:0]        o_present_after,
    output logic                              o_last
);

    localparam int IW = $clog2(NODES);

    logic [NODES-1:0] r_rows [NODES];
    logic [NODES-1:0] r_rd_data;
    logic [NODES-1:0] r_present;
    logic [NODES-1:0] r_check;
    logic [NODES-1:0] r_nb;
    logic [NODES-1:0] r_cand;
    logic [IW-1:0]    r_a;
    logic [IW-1:0]    r_n;
    logic [IW-1:0]    r_dom;

    logic                       r_out_valid;
    logic                       r_out_summary;
    logic [dvr_pkg::W_IDX-1:0]  r_out_removed;
    logic [dvr_pkg::W_IDX-1:0]  r_out_dom;
    logic [dvr_pkg::W_BITS-1:0] r_out_present;

    logic [NODES-1:0] bits_m;
    logic [NODES-1:0] self_m;
    logic [NODES-1:0] nb_now;
    logic [NODES-1:0] low_bit;
    logic [IW-1:0]    low_idx;
    logic [IW-1:0]    rd_addr;
    logic             row_in_range;
    logic             out_free;

    assign bits_m       = i_bits[NODES-1:0];
    assign self_m       = {{(NODES-1){1'b0}}, 1'b1} << r_a;
    assign nb_now       = r_rd_data & r_present;
    assign low_bit      = r_cand & (~r_cand + {{(NODES-1){1'b0}}, 1'b1});
    assign rd_addr      = i_cmd.rd_row_a ? r_a : r_n;
    assign row_in_range = (int'(i_row_index) < NODES);
    assign out_free     = !r_out_valid || !i_stall;

    always_comb begin
        low_idx = '0;
        for (int k = 0; k < NODES; k++) begin
            if (low_bit[k]) begin
                low_idx = low_idx | IW'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_row && row_in_range) begin
            r_rows[i_row_index[IW-1:0]] <= bits_m;
        end
        if (i_cmd.rd_row_a || i_cmd.rd_row_n) begin
            r_rd_data <= r_rows[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_a) begin
            r_a <= '0;
        end else if (i_cmd.inc_a) begin
            r_a <= r_a + 1'b1;
        end
        if (i_cmd.nb_latch) begin
            r_nb   <= nb_now;
            r_cand <= r_present & ~self_m;
            r_n    <= '0;
        end else begin
            if (i_cmd.inc_n) begin
                r_n <= r_n + 1'b1;
            end
            if (i_cmd.and_row) begin
                r_cand <= r_cand & r_rd_data;
            end
        end
        if (i_cmd.find_dom) begin
            r_dom <= low_idx;
        end
        if (i_cmd.out_report || i_cmd.out_summary) begin
            r_out_summary <= i_cmd.out_summary;
            r_out_removed <= i_cmd.out_report ? dvr_pkg::W_IDX'(r_a) : '0;
            r_out_dom     <= i_cmd.out_report ? dvr_pkg::W_IDX'(r_dom) : '0;
            r_out_present <= i_cmd.out_summary ? dvr_pkg::W_BITS'(r_present) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present   <= '0;
            r_check     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load_present) begin
                r_present <= bits_m;
            end else if (i_cmd.out_report) begin
                r_present <= r_present & ~self_m;
            end
            if (i_cmd.load_check) begin
                r_check <= bits_m;
            end
            if (i_cmd.out_report || i_cmd.out_summary) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.check_bit = r_check[r_a];
    assign o_status.a_last    = (r_a == IW'(NODES - 1));
    assign o_status.nb_zero   = (nb_now == '0);
    assign o_status.nb_bit    = r_nb[r_n];
    assign o_status.n_last    = (r_n == IW'(NODES - 1));
    assign o_status.cand_zero = (r_cand == '0);
    assign o_status.out_free  = out_free;

    assign o_valid          = r_out_valid;
    assign o_is_summary     = r_out_summary;
    assign o_pruned_node    = r_out_removed;
    assign o_dominator_node = r_out_dom;
    assign o_present_after  = r_out_present;
    assign o_last           = r_out_summary;

    `DVR_ASSERT(a_and_follows_read, i_clk, i_rst_n,
        i_cmd.and_row |-> $past(i_cmd.rd_row_n),
        "Row intersection without a preceding row read.")
    `DVR_ASSERT(a_report_clears_node, i_clk, i_rst_n,
        i_cmd.out_report |=> (r_present[$past(r_a)] == 1'b0),
        "Reported node still present after its report.")
    `DVR_ASSERT(a_dom_is_candidate, i_clk, i_rst_n,
        i_cmd.out_report |-> (r_cand[r_dom] == 1'b1),
        "Reported dominator is not a candidate.")

endmodule

// ----- hdl/dominated_vertex_removal_core.sv -----
// Dominated vertex removal core: a load request is taken while the core is
// idle. A run keeps the input stalled until its summary is loaded; it walks
// the checked nodes, scans the present neighbours of each one serially,
// intersects their rows, and waits on receiver stalls before each result.
// Results leave through an output register.
// Reset clears the present and check masks; adjacency rows are not cleared.
module dominated_vertex_removal_core #(
    parameter int NODES = dvr_pkg::NODES_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [1:0]                 i_command,
    input  logic [dvr_pkg::W_IDX-1:0]  i_row_index,
    input  logic [dvr_pkg::W_BITS-1:0] i_bits,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_is_summary,
    output logic [dvr_pkg::W_IDX-1:0]  o_pruned_node,
    output logic [dvr_pkg::W_IDX-1:0]  o_dominator_node,
    output logic [dvr_pkg::W_BITS-1:0] o_present_after,
    output logic                       o_last
);

    dvr_pkg::t_dp_cmd    cmd;
    dvr_pkg::t_dp_status status;

    dvr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .i_status  (status),
        .o_cmd     (cmd),
        .o_stall   (o_stall)
    );

    dvr_datapath #(
        .NODES (NODES)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_row_index      (i_row_index),
        .i_bits           (i_bits),
        .i_stall          (i_stall),
        .o_status         (status),
        .o_valid          (o_valid),
        .o_is_summary     (o_is_summary),
        .o_pruned_node    (o_pruned_node),
        .o_dominator_node (o_dominator_node),
        .o_present_after  (o_present_after),
        .o_last           (o_last)
    );

endmodule
